/* hw/rtl/rbgf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths, gradient ROM contents and palette map for the gradient fill core.
// Depends on nothing; every other file refers to it by scoped names.
package rbgf_pkg;

    localparam int COORD_BITS     = 12;
    localparam int DIM_BITS       = 13;
    localparam int FRACTION_BITS  = 16;
    localparam int GRADIENT_STEPS = 32;
    localparam int STEP_BITS      = $clog2(GRADIENT_STEPS);
    localparam int ROM_COUNT      = 7;
    localparam int ROM_ENTRIES    = GRADIENT_STEPS + 1;
    localparam int ROM_SEL_BITS   = 3;
    localparam int LO_BITS        = STEP_BITS + 1;
    localparam int ROM_IDX_BITS   = 8;
    localparam int CORNERS        = 4;
    localparam int CHANNELS       = 3;
    localparam int COLOR_BITS     = 8;

    // Corner coordinate and distance widths
    localparam int POS_W   = DIM_BITS + 1;
    localparam int SUM_W   = 2 * POS_W + 1;
    localparam int DIAG_W  = 2 * DIM_BITS + 1;
    localparam int DIV_STEPS = 2 * FRACTION_BITS + 2 * STEP_BITS;
    localparam int QUO_W   = DIV_STEPS;
    localparam int ROOT_W  = QUO_W / 2;
    localparam int REM_W   = ROOT_W + 2;

    // Blend widths
    localparam int K_W     = COLOR_BITS + FRACTION_BITS;
    localparam int TB_W    = K_W + DIM_BITS;
    localparam int NUM_W   = TB_W + DIM_BITS;
    localparam int DEN_W   = 2 * DIM_BITS;
    localparam int QUOT_BITS = COLOR_BITS + 1;
    localparam int N2_W    = NUM_W + 1 - FRACTION_BITS;

    // Pipeline depths
    localparam int FRONT_LAT = 3;
    localparam int RATIO_LAT = DIV_STEPS + 1;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int BLEND_LAT = 5 + QUOT_BITS;
    localparam int SIDE_LAT  = RATIO_LAT + SQRT_LAT;
    localparam int PIPE_LAT  = FRONT_LAT + SIDE_LAT + BLEND_LAT;

    localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RST = 13'd400;

    // Per-pixel data that rides alongside the distance pipeline
    typedef struct packed {
        logic [ROM_SEL_BITS-1:0] rom;
        logic [COORD_BITS-1:0]   ox;
        logic [COORD_BITS-1:0]   oy;
        logic [DIM_BITS-1:0]     wd;
        logic [DIM_BITS-1:0]     hd;
    } side_t;

    localparam logic [ROM_SEL_BITS-1:0] PALETTE_ROM [0:15] = '{
        3'd2, 3'd2, 3'd2, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2,
        3'd0, 3'd2, 3'd3, 3'd4, 3'd1, 3'd5, 3'd6, 3'd6
    };

    localparam logic [3*COLOR_BITS-1:0] GRAD_ROM [0:ROM_COUNT*ROM_ENTRIES-1] = '{
        {8'd0,8'd0,8'd0},{8'd0,8'd0,8'd8},{8'd0,8'd0,8'd16},{8'd0,8'd0,8'd24},
        {8'd0,8'd0,8'd32},{8'd0,8'd0,8'd40},{8'd0,8'd0,8'd48},{8'd0,8'd0,8'd56},
        {8'd0,8'd0,8'd64},{8'd0,8'd0,8'd72},{8'd0,8'd0,8'd80},{8'd0,8'd0,8'd88},
        {8'd0,8'd0,8'd96},{8'd0,8'd0,8'd104},{8'd0,8'd0,8'd112},{8'd0,8'd0,8'd120},
        {8'd0,8'd0,8'd132},{8'd0,8'd0,8'd140},{8'd0,8'd0,8'd148},{8'd0,8'd0,8'd156},
        {8'd0,8'd0,8'd164},{8'd0,8'd0,8'd172},{8'd0,8'd0,8'd180},{8'd0,8'd0,8'd188},
        {8'd0,8'd0,8'd196},{8'd0,8'd0,8'd204},{8'd0,8'd0,8'd212},{8'd0,8'd0,8'd220},
        {8'd0,8'd0,8'd228},{8'd0,8'd0,8'd236},{8'd0,8'd0,8'd244},{8'd0,8'd0,8'd252},
        {8'd0,8'd0,8'd252},

        {8'd108,8'd36,8'd0},{8'd112,8'd36,8'd0},{8'd116,8'd40,8'd0},{8'd120,8'd44,8'd0},
        {8'd124,8'd48,8'd0},{8'd128,8'd52,8'd0},{8'd136,8'd56,8'd0},{8'd140,8'd56,8'd0},
        {8'd144,8'd60,8'd0},{8'd148,8'd64,8'd0},{8'd152,8'd68,8'd0},{8'd156,8'd72,8'd0},
        {8'd164,8'd76,8'd0},{8'd168,8'd80,8'd0},{8'd172,8'd88,8'd0},{8'd176,8'd92,8'd0},
        {8'd180,8'd96,8'd0},{8'd184,8'd100,8'd0},{8'd192,8'd104,8'd0},{8'd196,8'd112,8'd0},
        {8'd200,8'd116,8'd0},{8'd204,8'd120,8'd0},{8'd208,8'd124,8'd0},{8'd212,8'd132,8'd0},
        {8'd216,8'd136,8'd0},{8'd224,8'd144,8'd0},{8'd228,8'd148,8'd0},{8'd232,8'd152,8'd0},
        {8'd236,8'd160,8'd0},{8'd240,8'd168,8'd0},{8'd244,8'd172,8'd0},{8'd252,8'd180,8'd0},
        {8'd252,8'd180,8'd0},

        {8'd36,8'd36,8'd36},{8'd40,8'd40,8'd40},{8'd48,8'd48,8'd48},{8'd56,8'd52,8'd52},
        {8'd60,8'd60,8'd60},{8'd68,8'd64,8'd64},{8'd76,8'd72,8'd72},{8'd80,8'd76,8'd76},
        {8'd88,8'd80,8'd80},{8'd96,8'd88,8'd88},{8'd104,8'd92,8'd92},{8'd108,8'd96,8'd96},
        {8'd116,8'd104,8'd104},{8'd124,8'd108,8'd108},{8'd128,8'd112,8'd112},
        {8'd136,8'd116,8'd116},{8'd144,8'd124,8'd124},{8'd148,8'd128,8'd128},
        {8'd156,8'd132,8'd132},{8'd164,8'd136,8'd136},{8'd168,8'd140,8'd140},
        {8'd176,8'd144,8'd144},{8'd184,8'd148,8'd148},{8'd188,8'd152,8'd152},
        {8'd196,8'd156,8'd156},{8'd204,8'd160,8'd160},{8'd212,8'd164,8'd164},
        {8'd216,8'd168,8'd168},{8'd224,8'd168,8'd168},{8'd232,8'd172,8'd172},
        {8'd236,8'd176,8'd176},{8'd244,8'd180,8'd180},{8'd244,8'd180,8'd180},

        {8'd252,8'd0,8'd0},{8'd252,8'd0,8'd0},{8'd252,8'd4,8'd4},{8'd252,8'd8,8'd8},
        {8'd252,8'd8,8'd8},{8'd252,8'd12,8'd12},{8'd252,8'd16,8'd16},{8'd252,8'd20,8'd20},
        {8'd252,8'd24,8'd24},{8'd252,8'd28,8'd28},{8'd252,8'd32,8'd32},{8'd252,8'd36,8'd36},
        {8'd252,8'd40,8'd40},{8'd252,8'd44,8'd44},{8'd252,8'd48,8'd48},{8'd252,8'd52,8'd52},
        {8'd252,8'd56,8'd56},{8'd252,8'd60,8'd60},{8'd252,8'd64,8'd64},{8'd252,8'd68,8'd68},
        {8'd252,8'd72,8'd72},{8'd252,8'd76,8'd76},{8'd252,8'd80,8'd80},{8'd252,8'd84,8'd84},
        {8'd252,8'd88,8'd88},{8'd252,8'd92,8'd92},{8'd252,8'd96,8'd96},
        {8'd252,8'd100,8'd100},{8'd252,8'd104,8'd104},{8'd252,8'd108,8'd108},
        {8'd252,8'd112,8'd112},{8'd252,8'd116,8'd116},{8'd252,8'd116,8'd116},

        {8'd108,8'd0,8'd36},{8'd112,8'd0,8'd44},{8'd116,8'd0,8'd52},{8'd120,8'd4,8'd64},
        {8'd124,8'd4,8'd72},{8'd128,8'd8,8'd84},{8'd136,8'd12,8'd92},{8'd140,8'd12,8'd104},
        {8'd144,8'd16,8'd116},{8'd148,8'd20,8'd128},{8'd152,8'd24,8'd136},
        {8'd156,8'd28,8'd148},{8'd164,8'd32,8'd160},{8'd160,8'd36,8'd168},
        {8'd160,8'd40,8'd172},{8'd156,8'd44,8'd176},{8'd152,8'd48,8'd180},
        {8'd152,8'd56,8'd184},{8'd152,8'd60,8'd192},{8'd148,8'd64,8'd196},
        {8'd144,8'd72,8'd200},{8'd144,8'd76,8'd204},{8'd144,8'd84,8'd208},
        {8'd140,8'd88,8'd212},{8'd140,8'd96,8'd216},{8'd140,8'd100,8'd224},
        {8'd140,8'd108,8'd228},{8'd140,8'd112,8'd232},{8'd140,8'd120,8'd236},
        {8'd140,8'd128,8'd240},{8'd140,8'd136,8'd244},{8'd144,8'd144,8'd252},
        {8'd144,8'd144,8'd252},

        {8'd0,8'd0,8'd252},{8'd0,8'd4,8'd248},{8'd4,8'd16,8'd248},{8'd4,8'd28,8'd248},
        {8'd8,8'd36,8'd244},{8'd12,8'd48,8'd244},{8'd12,8'd60,8'd244},{8'd16,8'd68,8'd244},
        {8'd20,8'd76,8'd240},{8'd20,8'd84,8'd240},{8'd24,8'd96,8'd240},
        {8'd28,8'd104,8'd236},{8'd32,8'd112,8'd236},{8'd32,8'd116,8'd236},
        {8'd36,8'd124,8'd236},{8'd40,8'd132,8'd232},{8'd40,8'd140,8'd232},
        {8'd44,8'd148,8'd232},{8'd48,8'd152,8'd228},{8'd48,8'd160,8'd228},
        {8'd52,8'd164,8'd228},{8'd56,8'd172,8'd228},{8'd56,8'd176,8'd224},
        {8'd60,8'd180,8'd224},{8'd64,8'd188,8'd224},{8'd64,8'd192,8'd220},
        {8'd68,8'd196,8'd220},{8'd68,8'd200,8'd220},{8'd72,8'd204,8'd216},
        {8'd76,8'd208,8'd216},{8'd76,8'd212,8'd216},{8'd80,8'd216,8'd216},
        {8'd80,8'd216,8'd216},

        {8'd16,8'd32,8'd0},{8'd16,8'd44,8'd0},{8'd20,8'd56,8'd0},{8'd24,8'd68,8'd0},
        {8'd24,8'd80,8'd0},{8'd28,8'd88,8'd0},{8'd28,8'd100,8'd0},{8'd32,8'd112,8'd0},
        {8'd32,8'd124,8'd0},{8'd36,8'd136,8'd0},{8'd36,8'd144,8'd0},{8'd48,8'd152,8'd0},
        {8'd60,8'd156,8'd0},{8'd68,8'd160,8'd0},{8'd80,8'd168,8'd0},{8'd88,8'd172,8'd0},
        {8'd100,8'd176,8'd0},{8'd108,8'd180,8'd0},{8'd120,8'd188,8'd0},
        {8'd132,8'd192,8'd0},{8'd140,8'd196,8'd0},{8'd152,8'd204,8'd0},
        {8'd160,8'd208,8'd0},{8'd172,8'd212,8'd0},{8'd180,8'd216,8'd0},
        {8'd192,8'd224,8'd0},{8'd204,8'd228,8'd0},{8'd212,8'd232,8'd0},
        {8'd224,8'd240,8'd0},{8'd232,8'd244,8'd0},{8'd244,8'd248,8'd0},
        {8'd252,8'd252,8'd0},{8'd252,8'd252,8'd0}
    };

    // RGB entry of one gradient at one step
    function automatic logic [3*COLOR_BITS-1:0] grad_color(
        input logic [ROM_SEL_BITS-1:0] rom,
        input logic [LO_BITS-1:0]      lo
    );
        logic [ROM_IDX_BITS-1:0] idx;
        idx = {rom, 5'b00000} + ROM_IDX_BITS'(rom) + ROM_IDX_BITS'(lo);
        return GRAD_ROM[idx];
    endfunction

endpackage

/* hw/rtl/rbgf_front.sv */
`timescale 1ns / 1ps
// Front end: clamps the request fields, forms the corner coordinates and their squared
// distances from the lower-left origin over three stages. Uses rbgf_pkg.
module rbgf_front (
    input  logic                                clk,
    input  logic                                adv,
    input  logic [rbgf_pkg::DIM_BITS-1:0]       screen_height,
    input  logic [rbgf_pkg::COORD_BITS-1:0]     dest_x,
    input  logic [rbgf_pkg::COORD_BITS-1:0]     dest_y,
    input  logic [rbgf_pkg::DIM_BITS-1:0]       rect_width,
    input  logic [rbgf_pkg::DIM_BITS-1:0]       rect_height,
    input  logic [3:0]                          color_index,
    input  logic [rbgf_pkg::COORD_BITS-1:0]     offset_x,
    input  logic [rbgf_pkg::COORD_BITS-1:0]     offset_y,
    output logic [rbgf_pkg::CORNERS-1:0][rbgf_pkg::SUM_W-1:0] dist_sq,
    output rbgf_pkg::side_t                     side
);

    localparam int PW = rbgf_pkg::POS_W;
    localparam int DW = rbgf_pkg::DIM_BITS;
    localparam int CW = rbgf_pkg::COORD_BITS;
    localparam int SW = PW + 1;

    logic [DW-1:0] w, h, sh_e, w_m1, h_m1;
    logic [CW-1:0] ox, oy;
    logic [SW-1:0] d1, d2;

    logic [CW-1:0]   x1_reg, x1_next;
    logic [PW-1:0]   x2_reg, x2_next;
    logic [DW-1:0]   y1_reg, y1_next;
    logic [PW-1:0]   y2_reg, y2_next;
    rbgf_pkg::side_t side1_reg, side1_next, side2_reg, side3_reg;

    logic [2*CW-1:0] x1sq_reg;
    logic [2*PW-1:0] x2sq_reg;
    logic [2*DW-1:0] y1sq_reg;
    logic [2*PW-1:0] y2sq_reg;
    logic [rbgf_pkg::CORNERS-1:0][rbgf_pkg::SUM_W-1:0] sum_reg, sum_next;

    always_comb
    begin
        w    = (rect_width == '0)    ? DW'(1) : rect_width;
        h    = (rect_height == '0)   ? DW'(1) : rect_height;
        sh_e = (screen_height == '0) ? DW'(1) : screen_height;
        w_m1 = w - DW'(1);
        h_m1 = h - DW'(1);

        // Saturate the offset to the last column or row
        ox = (DW'(offset_x) > w_m1) ? w_m1[CW-1:0] : offset_x;
        oy = (DW'(offset_y) > h_m1) ? h_m1[CW-1:0] : offset_y;

        x1_next = dest_x;
        x2_next = PW'(dest_x) + PW'(w_m1);

        // Rows count upward; a corner below the origin counts by magnitude
        d1 = SW'(sh_e) - SW'(1) - SW'(dest_y);
        d2 = SW'(sh_e) - SW'(dest_y) - SW'(h);
        y1_next = d1[SW-1] ? DW'(~d1 + SW'(1)) : d1[DW-1:0];
        y2_next = d2[SW-1] ? PW'(~d2 + SW'(1)) : d2[PW-1:0];

        side1_next.rom = rbgf_pkg::PALETTE_ROM[color_index];
        side1_next.ox  = ox;
        side1_next.oy  = oy;
        side1_next.wd  = (w > DW'(1)) ? w_m1 : DW'(1);
        side1_next.hd  = (h > DW'(1)) ? h_m1 : DW'(1);
    end

    always_comb
    begin
        sum_next[0] = rbgf_pkg::SUM_W'(x1sq_reg) + rbgf_pkg::SUM_W'(y1sq_reg);
        sum_next[1] = rbgf_pkg::SUM_W'(x2sq_reg) + rbgf_pkg::SUM_W'(y1sq_reg);
        sum_next[2] = rbgf_pkg::SUM_W'(x1sq_reg) + rbgf_pkg::SUM_W'(y2sq_reg);
        sum_next[3] = rbgf_pkg::SUM_W'(x2sq_reg) + rbgf_pkg::SUM_W'(y2sq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg    <= x1_next;
            x2_reg    <= x2_next;
            y1_reg    <= y1_next;
            y2_reg    <= y2_next;
            side1_reg <= side1_next;

            x1sq_reg  <= (2*CW)'(x1_reg) * (2*CW)'(x1_reg);
            x2sq_reg  <= (2*PW)'(x2_reg) * (2*PW)'(x2_reg);
            y1sq_reg  <= (2*DW)'(y1_reg) * (2*DW)'(y1_reg);
            y2sq_reg  <= (2*PW)'(y2_reg) * (2*PW)'(y2_reg);
            side2_reg <= side1_reg;

            sum_reg   <= sum_next;
            side3_reg <= side2_reg;
        end
    end

    assign dist_sq = sum_reg;
    assign side    = side3_reg;

endmodule

/* hw/rtl/rbgf_ratio.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: squared distance over squared diagonal, scaled by the
// step count squared, one quotient bit per stage. Uses rbgf_pkg.
module rbgf_ratio (
    input  logic                              clk,
    input  logic                              adv,
    input  logic [rbgf_pkg::SUM_W-1:0]        dist_sq,
    input  logic [rbgf_pkg::DIAG_W-1:0]       diag_sq,
    output logic [rbgf_pkg::QUO_W-1:0]        ratio,
    output logic                              sat
);

    localparam int N  = rbgf_pkg::DIV_STEPS;
    localparam int DW = rbgf_pkg::DIAG_W;
    localparam int QW = rbgf_pkg::QUO_W;

    logic [DW-1:0]  rem_reg  [0:N-1];
    logic [DW-1:0]  rem_next [0:N-1];
    logic [QW-1:0]  quo_reg  [0:N];
    logic [QW-1:0]  quo_next [0:N];
    logic [N:0]     sat_reg, sat_next;

    always_comb
    begin
        logic [DW:0] dbl;
        logic [DW:0] diff;
        sat_next[0] = (dist_sq >= rbgf_pkg::SUM_W'(diag_sq));
        rem_next[0] = sat_next[0] ? '0 : dist_sq[DW-1:0];
        quo_next[0] = '0;
        for (int i = 0; i < N; i++)
        begin
            dbl  = {rem_reg[i], 1'b0};
            diff = dbl - {1'b0, diag_sq};
            sat_next[i+1] = sat_reg[i];
            if (dbl >= {1'b0, diag_sq})
            begin
                quo_next[i+1] = {quo_reg[i][QW-2:0], 1'b1};
                if (i + 1 < N)
                begin
                    rem_next[i+1] = diff[DW-1:0];
                end
            end
            else
            begin
                quo_next[i+1] = {quo_reg[i][QW-2:0], 1'b0};
                if (i + 1 < N)
                begin
                    rem_next[i+1] = dbl[DW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i] <= rem_next[i];
            end
            for (int i = 0; i <= N; i++)
            begin
                quo_reg[i] <= quo_next[i];
            end
            sat_reg <= sat_next;
        end
    end

    assign ratio = quo_reg[N];
    assign sat   = sat_reg[N];

endmodule

/* hw/rtl/rbgf_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, one root bit per stage, giving the
// gradient position with FRACTION_BITS fraction bits. Uses rbgf_pkg.
module rbgf_sqrt (
    input  logic                              clk,
    input  logic                              adv,
    input  logic [rbgf_pkg::QUO_W-1:0]        ratio,
    input  logic                              sat_in,
    output logic [rbgf_pkg::ROOT_W-1:0]       root,
    output logic                              sat
);

    localparam int N  = rbgf_pkg::ROOT_W;
    localparam int RW = rbgf_pkg::REM_W;
    localparam int QW = rbgf_pkg::QUO_W;
    localparam int CW = RW + 2;

    logic [RW-1:0] rem_reg  [0:N-1];
    logic [RW-1:0] rem_next [0:N-1];
    logic [N-1:0]  root_reg [0:N-1];
    logic [N-1:0]  root_next[0:N-1];
    logic [QW-1:0] bits_reg [0:N-1];
    logic [QW-1:0] bits_next[0:N-1];
    logic [N-1:0]  sat_reg, sat_next;

    always_comb
    begin
        logic [RW-1:0] prem;
        logic [N-1:0]  proot;
        logic [QW-1:0] pbits;
        logic [CW-1:0] cur;
        logic [CW-1:0] trial;
        logic [CW-1:0] diff;
        for (int i = 0; i < N; i++)
        begin
            if (i == 0)
            begin
                prem        = '0;
                proot       = '0;
                pbits       = ratio;
                sat_next[i] = sat_in;
            end
            else
            begin
                prem        = rem_reg[i-1];
                proot       = root_reg[i-1];
                pbits       = bits_reg[i-1];
                sat_next[i] = sat_reg[i-1];
            end
            // Bring down the next two radicand bits
            cur          = {prem, pbits[QW-1 -: 2]};
            trial        = CW'({proot, 2'b01});
            diff         = cur - trial;
            bits_next[i] = {pbits[QW-3:0], 2'b00};
            if (cur >= trial)
            begin
                rem_next[i]  = diff[RW-1:0];
                root_next[i] = {proot[N-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = cur[RW-1:0];
                root_next[i] = {proot[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                bits_reg[i] <= bits_next[i];
            end
            sat_reg <= sat_next;
        end
    end

    assign root = root_reg[N-1];
    assign sat  = sat_reg[N-1];

endmodule

/* hw/rtl/rbgf_blend.sv */
`timescale 1ns / 1ps
// Color blend: gradient ROM lookup and linear blend per corner, bilinear blend across
// the rectangle, then a pipelined divide that rounds half up. Uses rbgf_pkg.
module rbgf_blend (
    input  logic                                               clk,
    input  logic                                               adv,
    input  rbgf_pkg::side_t                                    side,
    input  logic [rbgf_pkg::CORNERS-1:0][rbgf_pkg::ROOT_W-1:0] root,
    input  logic [rbgf_pkg::CORNERS-1:0]                       sat,
    output logic [rbgf_pkg::COLOR_BITS-1:0]                    red,
    output logic [rbgf_pkg::COLOR_BITS-1:0]                    green,
    output logic [rbgf_pkg::COLOR_BITS-1:0]                    blue
);

    localparam int NC  = rbgf_pkg::CORNERS;
    localparam int NCH = rbgf_pkg::CHANNELS;
    localparam int CB  = rbgf_pkg::COLOR_BITS;
    localparam int FB  = rbgf_pkg::FRACTION_BITS;
    localparam int KW  = rbgf_pkg::K_W;
    localparam int TW  = rbgf_pkg::TB_W;
    localparam int NW  = rbgf_pkg::NUM_W;
    localparam int DNW = rbgf_pkg::DEN_W;
    localparam int N2W = rbgf_pkg::N2_W;
    localparam int QB  = rbgf_pkg::QUOT_BITS;
    localparam int DIM = rbgf_pkg::DIM_BITS;

    // Stage 1: ROM entries around the position
    logic [CB-1:0]   c1_reg [0:NC-1][0:NCH-1];
    logic [CB-1:0]   c2_reg [0:NC-1][0:NCH-1];
    logic [CB-1:0]   c1_next[0:NC-1][0:NCH-1];
    logic [CB-1:0]   c2_next[0:NC-1][0:NCH-1];
    logic [FB-1:0]   f_reg  [0:NC-1];
    logic [FB-1:0]   f_next [0:NC-1];
    rbgf_pkg::side_t side1_reg, side2_reg;

    // Stage 2: corner colors
    logic [KW-1:0]   k_reg  [0:NC-1][0:NCH-1];
    logic [KW-1:0]   k_next [0:NC-1][0:NCH-1];

    // Stage 3: horizontal blend
    logic [TW-1:0]   top_reg[0:NCH-1];
    logic [TW-1:0]   bot_reg[0:NCH-1];
    logic [DNW-1:0]  den3_reg;
    logic [DIM-1:0]  hd3_reg;
    logic [rbgf_pkg::COORD_BITS-1:0] oy3_reg;

    // Stage 4: vertical products
    logic [NW-1:0]   pt_reg [0:NCH-1];
    logic [NW-1:0]   pb_reg [0:NCH-1];
    logic [DNW-1:0]  den4_reg;

    // Stage 5 and divider stages
    logic [N2W-1:0]  rem_reg [0:QB][0:NCH-1];
    logic [N2W-1:0]  rem_next[0:QB][0:NCH-1];
    logic [QB-1:0]   quo_reg [0:QB][0:NCH-1];
    logic [QB-1:0]   quo_next[0:QB][0:NCH-1];
    logic [DNW-1:0]  den_reg [0:QB];

    logic [DIM-1:0]  wa;
    logic [DIM-1:0]  hb;
    logic [CB-1:0]   pix [0:NCH-1];

    always_comb
    begin
        logic [rbgf_pkg::LO_BITS-1:0] lo;
        logic [3*CB-1:0] e1;
        logic [3*CB-1:0] e2;
        for (int k = 0; k < NC; k++)
        begin
            lo = sat[k] ? rbgf_pkg::LO_BITS'(rbgf_pkg::GRADIENT_STEPS)
                        : rbgf_pkg::LO_BITS'(root[k][rbgf_pkg::ROOT_W-1:FB]);
            f_next[k] = sat[k] ? '0 : root[k][FB-1:0];
            e1 = rbgf_pkg::grad_color(side.rom, lo);
            // Past the last step both neighbors are the last entry
            e2 = sat[k] ? e1 : rbgf_pkg::grad_color(side.rom, lo + rbgf_pkg::LO_BITS'(1));
            for (int c = 0; c < NCH; c++)
            begin
                c1_next[k][c] = e1[(NCH-1-c)*CB +: CB];
                c2_next[k][c] = e2[(NCH-1-c)*CB +: CB];
            end
        end
    end

    always_comb
    begin
        logic [FB:0]   inv_f;
        logic [KW:0]   mix;
        for (int k = 0; k < NC; k++)
        begin
            inv_f = (FB+1)'(1) << FB;
            inv_f = inv_f - (FB+1)'(f_reg[k]);
            for (int c = 0; c < NCH; c++)
            begin
                mix = (KW+1)'(c1_reg[k][c]) * (KW+1)'(inv_f)
                    + (KW+1)'(c2_reg[k][c]) * (KW+1)'(f_reg[k]);
                k_next[k][c] = mix[KW-1:0];
            end
        end
    end

    assign wa = side2_reg.wd - DIM'(side2_reg.ox);
    assign hb = hd3_reg - DIM'(oy3_reg);

    always_comb
    begin
        logic [DNW-1:0] dsh;
        logic [N2W:0]   num_r;
        for (int c = 0; c < NCH; c++)
        begin
            // Add half the divisor, drop the fraction bits, then divide by wd * hd
            num_r = (N2W+1)'((pt_reg[c] + pb_reg[c] + (NW'(den4_reg) << (FB - 1))) >> FB);
            rem_next[0][c] = num_r[N2W-1:0];
            quo_next[0][c] = '0;
        end
        for (int j = 0; j < QB; j++)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                dsh = '0;
                if (rem_reg[j][c] >= (N2W'(den_reg[j]) << (QB - 1 - j)))
                begin
                    rem_next[j+1][c] = rem_reg[j][c] - (N2W'(den_reg[j]) << (QB - 1 - j));
                    quo_next[j+1][c] = {quo_reg[j][c][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j+1][c] = rem_reg[j][c] | N2W'(dsh);
                    quo_next[j+1][c] = {quo_reg[j][c][QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NC; k++)
            begin
                f_reg[k] <= f_next[k];
                for (int c = 0; c < NCH; c++)
                begin
                    c1_reg[k][c] <= c1_next[k][c];
                    c2_reg[k][c] <= c2_next[k][c];
                    k_reg[k][c]  <= k_next[k][c];
                end
            end
            side1_reg <= side;
            side2_reg <= side1_reg;

            for (int c = 0; c < NCH; c++)
            begin
                top_reg[c] <= TW'(k_reg[0][c]) * TW'(wa) + TW'(k_reg[1][c]) * TW'(side2_reg.ox);
                bot_reg[c] <= TW'(k_reg[2][c]) * TW'(wa) + TW'(k_reg[3][c]) * TW'(side2_reg.ox);
                pt_reg[c]  <= NW'(top_reg[c]) * NW'(hb);
                pb_reg[c]  <= NW'(bot_reg[c]) * NW'(oy3_reg);
            end
            den3_reg <= DNW'(side2_reg.wd) * DNW'(side2_reg.hd);
            hd3_reg  <= side2_reg.hd;
            oy3_reg  <= side2_reg.oy;
            den4_reg <= den3_reg;

            den_reg[0] <= den4_reg;
            for (int j = 0; j < QB; j++)
            begin
                den_reg[j+1] <= den_reg[j];
            end
            for (int j = 0; j <= QB; j++)
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    rem_reg[j][c] <= rem_next[j][c];
                    quo_reg[j][c] <= quo_next[j][c];
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            pix[c] = quo_reg[QB][c][QB-1] ? {CB{1'b1}} : quo_reg[QB][c][CB-1:0];
        end
    end

    assign red   = pix[0];
    assign green = pix[1];
    assign blue  = pix[2];

endmodule

/* hw/rtl/radial_bilinear_gradient_fill_core.sv */
`timescale 1ns / 1ps
// Radial bilinear gradient fill core: one RGB pixel per request, fully pipelined.
// Uses rbgf_pkg, rbgf_front, rbgf_ratio, rbgf_sqrt and rbgf_blend.
//
// Takes one pixel request per clock and returns its color; with the output free, the
// sustained rate is one pixel per clock. The pipeline is made of the four per-corner
// distance dividers (43 stages: a saturation check, then one quotient bit each) and
// square roots (21 stages), plus 3 front and 14 blend and rounding stages. Results
// leave through an output register backed by one skid entry, so requests keep flowing
// while a pixel waits; req_stall rises only once the skid entry is taken. Write the
// screen size registers only while no pixel is in flight. No clearing pass after reset.
module radial_bilinear_gradient_fill_core (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,

    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [rbgf_pkg::COORD_BITS-1:0]    dest_x,
    input  logic [rbgf_pkg::COORD_BITS-1:0]    dest_y,
    input  logic [rbgf_pkg::DIM_BITS-1:0]      rect_width,
    input  logic [rbgf_pkg::DIM_BITS-1:0]      rect_height,
    input  logic [3:0]                         color_index,
    input  logic [rbgf_pkg::COORD_BITS-1:0]    offset_x,
    input  logic [rbgf_pkg::COORD_BITS-1:0]    offset_y,

    output logic                               pixel_valid,
    input  logic                               pixel_stall,
    output logic [rbgf_pkg::COLOR_BITS-1:0]    red,
    output logic [rbgf_pkg::COLOR_BITS-1:0]    green,
    output logic [rbgf_pkg::COLOR_BITS-1:0]    blue
);

    localparam int DW = rbgf_pkg::DIM_BITS;
    localparam int CB = rbgf_pkg::COLOR_BITS;
    localparam int NC = rbgf_pkg::CORNERS;

    logic [DW-1:0] screen_width_reg, screen_height_reg;
    logic [DW-1:0] sw_e, sh_e;
    logic [rbgf_pkg::DIAG_W-1:0] diag_reg;
    logic cfg_wr;

    logic adv;
    logic accept;
    logic [rbgf_pkg::PIPE_LAT-1:0] valid_reg, valid_next;
    logic last_valid;

    logic [NC-1:0][rbgf_pkg::SUM_W-1:0]  dist_sq;
    logic [NC-1:0][rbgf_pkg::QUO_W-1:0]  ratio;
    logic [NC-1:0]                       ratio_sat;
    logic [NC-1:0][rbgf_pkg::ROOT_W-1:0] root;
    logic [NC-1:0]                       root_sat;
    rbgf_pkg::side_t front_side;
    rbgf_pkg::side_t side_reg [0:rbgf_pkg::SIDE_LAT-1];

    logic [CB-1:0] pix_r, pix_g, pix_b;
    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [CB-1:0] out_r_reg, out_g_reg, out_b_reg;
    logic [CB-1:0] skid_r_reg, skid_g_reg, skid_b_reg;
    logic          take, push, load_out, load_skid, out_from_skid;

    // Configuration port
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(screen_height_reg) : 32'(screen_width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= rbgf_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= rbgf_pkg::SCREEN_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                screen_height_reg <= pwdata[DW-1:0];
            end
            else
            begin
                screen_width_reg <= pwdata[DW-1:0];
            end
        end
    end

    assign sw_e = (screen_width_reg == '0)  ? DW'(1) : screen_width_reg;
    assign sh_e = (screen_height_reg == '0) ? DW'(1) : screen_height_reg;

    always_ff @(posedge clk)
    begin
        diag_reg <= rbgf_pkg::DIAG_W'(sw_e) * rbgf_pkg::DIAG_W'(sw_e)
                  + rbgf_pkg::DIAG_W'(sh_e) * rbgf_pkg::DIAG_W'(sh_e);
    end

    // Whole pipeline moves together; it freezes only while the skid entry is full
    assign adv       = !skid_valid_reg;
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid & adv;

    assign valid_next = {valid_reg[rbgf_pkg::PIPE_LAT-2:0], accept};
    assign last_valid = valid_reg[rbgf_pkg::PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    rbgf_front u_front (
        .clk           (clk),
        .adv           (adv),
        .screen_height (screen_height_reg),
        .dest_x        (dest_x),
        .dest_y        (dest_y),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .color_index   (color_index),
        .offset_x      (offset_x),
        .offset_y      (offset_y),
        .dist_sq       (dist_sq),
        .side          (front_side)
    );

    for (genvar k = 0; k < NC; k++)
    begin : g_corner
        rbgf_ratio u_ratio (
            .clk     (clk),
            .adv     (adv),
            .dist_sq (dist_sq[k]),
            .diag_sq (diag_reg),
            .ratio   (ratio[k]),
            .sat     (ratio_sat[k])
        );

        rbgf_sqrt u_sqrt (
            .clk    (clk),
            .adv    (adv),
            .ratio  (ratio[k]),
            .sat_in (ratio_sat[k]),
            .root   (root[k]),
            .sat    (root_sat[k])
        );
    end

    // Hold the per-pixel fields level with the distance pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= front_side;
            for (int i = 1; i < rbgf_pkg::SIDE_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    rbgf_blend u_blend (
        .clk   (clk),
        .adv   (adv),
        .side  (side_reg[rbgf_pkg::SIDE_LAT-1]),
        .root  (root),
        .sat   (root_sat),
        .red   (pix_r),
        .green (pix_g),
        .blue  (pix_b)
    );

    // Output register with one skid entry
    always_comb
    begin
        take          = out_valid_reg & !pixel_stall;
        push          = adv & last_valid;
        out_from_skid = skid_valid_reg & take;
        load_out      = push & (!out_valid_reg | take);
        load_skid     = push & out_valid_reg & !take;

        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = load_skid;
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
        begin
            out_r_reg <= skid_r_reg;
            out_g_reg <= skid_g_reg;
            out_b_reg <= skid_b_reg;
        end
        else if (load_out)
        begin
            out_r_reg <= pix_r;
            out_g_reg <= pix_g;
            out_b_reg <= pix_b;
        end
        if (load_skid)
        begin
            skid_r_reg <= pix_r;
            skid_g_reg <= pix_g;
            skid_b_reg <= pix_b;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign red         = out_r_reg;
    assign green       = out_g_reg;
    assign blue        = out_b_reg;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Testbench for radial_bilinear_gradient_fill_core: predicts each pixel color and compares.
// Depends on rbgf_pkg and the core RTL only.
module testbench;

    typedef logic [rbgf_pkg::COORD_BITS-1:0] coord_t;
    typedef logic [rbgf_pkg::DIM_BITS-1:0]   dim_t;

    localparam logic [2:0] ADDR_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_SCREEN_HEIGHT = 3'd4;
    localparam int IDLE_PCT       = 9;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_WAIT     = 2 * rbgf_pkg::PIPE_LAT;
    localparam int HOLDOFF_CYCLES = 400;

    typedef struct {
        coord_t     dx;
        coord_t     dy;
        dim_t       w;
        dim_t       h;
        logic [3:0] cidx;
        coord_t     ox;
        coord_t     oy;
    } pixel_req_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef logic [2:0][63:0] corner_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic req_valid = 1'b0;
    logic req_stall;
    coord_t dest_x = '0, dest_y = '0, offset_x = '0, offset_y = '0;
    dim_t rect_width = '0, rect_height = '0;
    logic [3:0] color_index = '0;
    logic pixel_valid;
    logic pixel_stall = 1'b0;
    logic [7:0] red, green, blue;

    rgb_t colors_due[$];
    longint unsigned scr_w = 640, scr_h = 400;
    int errors = 0;
    bit steady = 0;
    int holdoff_asked = 0;
    int holdoff_seen = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    radial_bilinear_gradient_fill_core u_dut (.*);

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Color at one rectangle corner, 16 fraction bits per channel
    function automatic corner_t corner_shade(longint unsigned x, longint unsigned y,
                                             longint unsigned diag, int rom);
        longint unsigned s, a, q, rem, g, f, c1, c2;
        int lo;
        logic [23:0] e1, e2;
        corner_t k;
        s = x * x + y * y;
        if (s >= diag)
        begin
            lo = rbgf_pkg::GRADIENT_STEPS;
            f = 64'd0;
        end
        else
        begin
            a = s * rbgf_pkg::GRADIENT_STEPS * rbgf_pkg::GRADIENT_STEPS;
            q = a / diag;
            rem = a % diag;
            for (int i = 0; i < 2 * rbgf_pkg::FRACTION_BITS; i++)
            begin
                rem <<= 1;
                q <<= 1;
                if (rem >= diag)
                begin
                    rem -= diag;
                    q |= 64'd1;
                end
            end
            g = int_sqrt(q);
            lo = int'(g >> rbgf_pkg::FRACTION_BITS);
            f = g & ((64'd1 << rbgf_pkg::FRACTION_BITS) - 64'd1);
            if (lo >= rbgf_pkg::GRADIENT_STEPS)
            begin
                lo = rbgf_pkg::GRADIENT_STEPS;
                f = 64'd0;
            end
        end
        e1 = rbgf_pkg::GRAD_ROM[rom * rbgf_pkg::ROM_ENTRIES + lo];
        e2 = (lo < rbgf_pkg::GRADIENT_STEPS) ?
             rbgf_pkg::GRAD_ROM[rom * rbgf_pkg::ROM_ENTRIES + lo + 1] : e1;
        for (int c = 0; c < 3; c++)
        begin
            c1 = 64'(e1[(2 - c) * 8 +: 8]);
            c2 = 64'(e2[(2 - c) * 8 +: 8]);
            k[c] = c1 * ((64'd1 << rbgf_pkg::FRACTION_BITS) - f) + c2 * f;
        end
        return k;
    endfunction

    function automatic rgb_t predict_color(pixel_req_t p);
        longint unsigned sw, sh, diag, w, h, ox, oy, x1, x2, y1, y2, wd, hd, den, num, v;
        longint signed t1, t2;
        int rom;
        corner_t k1, k2, k3, k4;
        logic [2:0][7:0] res;
        sw = scr_w ? scr_w : 64'd1;
        sh = scr_h ? scr_h : 64'd1;
        diag = sw * sw + sh * sh;
        w = p.w ? 64'(p.w) : 64'd1;
        h = p.h ? 64'(p.h) : 64'd1;
        ox = (64'(p.ox) > w - 1) ? w - 1 : 64'(p.ox);
        oy = (64'(p.oy) > h - 1) ? h - 1 : 64'(p.oy);
        rom = int'(rbgf_pkg::PALETTE_ROM[p.cidx]);
        x1 = 64'(p.dx);
        x2 = 64'(p.dx) + w - 1;
        t1 = longint'(sh) - 1 - longint'(p.dy);
        t2 = longint'(sh) - longint'(p.dy) - longint'(h);
        y1 = (t1 < 0) ? -t1 : t1;
        y2 = (t2 < 0) ? -t2 : t2;
        k1 = corner_shade(x1, y1, diag, rom);
        k2 = corner_shade(x2, y1, diag, rom);
        k3 = corner_shade(x1, y2, diag, rom);
        k4 = corner_shade(x2, y2, diag, rom);
        wd = (w > 1) ? w - 1 : 64'd1;
        hd = (h > 1) ? h - 1 : 64'd1;
        if (w == 1)
            ox = 64'd0;
        if (h == 1)
            oy = 64'd0;
        den = wd * hd;
        for (int c = 0; c < 3; c++)
        begin
            num = k1[c] * (hd - oy) * (wd - ox) + k2[c] * (hd - oy) * ox
                + k3[c] * oy * (wd - ox) + k4[c] * oy * ox;
            v = (num + (den << (rbgf_pkg::FRACTION_BITS - 1)))
              / (den << rbgf_pkg::FRACTION_BITS);
            res[c] = (v > 255) ? 8'd255 : v[7:0];
        end
        return '{r: res[0], g: res[1], b: res[2]};
    endfunction

    // Call at a rising edge; returns at the edge that accepts the request
    task automatic send_pixel(pixel_req_t p);
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        req_valid   <= 1'b1;
        dest_x      <= p.dx;
        dest_y      <= p.dy;
        rect_width  <= p.w;
        rect_height <= p.h;
        color_index <= p.cidx;
        offset_x    <= p.ox;
        offset_y    <= p.oy;
        do @(posedge clk); while (req_stall);
        colors_due = {colors_due, predict_color(p)};
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (colors_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SCREEN_WIDTH)
            scr_w = 64'(data & 32'h1FFF);
        else
            scr_h = 64'(data & 32'h1FFF);
    endtask

    task automatic set_screen(logic [31:0] w, logic [31:0] h);
        apb_write(ADDR_SCREEN_WIDTH, w);
        apb_write(ADDR_SCREEN_HEIGHT, h);
    endtask

    function automatic pixel_req_t make_pixel(int dx, int dy, int w, int h, int ci,
                                              int ox, int oy);
        pixel_req_t p;
        p.dx   = coord_t'(dx);
        p.dy   = coord_t'(dy);
        p.w    = dim_t'(w);
        p.h    = dim_t'(h);
        p.cidx = 4'(ci);
        p.ox   = coord_t'(ox);
        p.oy   = coord_t'(oy);
        return p;
    endfunction

    function automatic pixel_req_t random_pixel();
        pixel_req_t p;
        int pick;
        p.dx = coord_t'($urandom);
        p.dy = coord_t'($urandom);
        p.cidx = 4'($urandom);
        pick = int'($urandom_range(99));
        p.w = dim_t'((pick < 60) ? $urandom_range(1, 64) :
                     (pick < 90) ? $urandom_range(1, 4096) : $urandom_range(0, 8191));
        pick = int'($urandom_range(99));
        p.h = dim_t'((pick < 60) ? $urandom_range(1, 64) :
                     (pick < 90) ? $urandom_range(1, 4096) : $urandom_range(0, 8191));
        // mostly offsets inside the rectangle; the rest are random and may saturate
        if ($urandom_range(99) < 85)
        begin
            p.ox = coord_t'($urandom_range(0, (p.w > dim_t'(1)) ? int'(p.w) - 1 : 0));
            p.oy = coord_t'($urandom_range(0, (p.h > dim_t'(1)) ? int'(p.h) - 1 : 0));
        end
        else
        begin
            p.ox = coord_t'($urandom);
            p.oy = coord_t'($urandom);
        end
        return p;
    endfunction

    task automatic test_directed();
        for (int ci = 0; ci < 16; ci++)
            send_pixel(make_pixel(ci * 40, ci * 25, 64, 32, ci, ci * 4, ci * 2));
        send_pixel(make_pixel(0, 0, 1, 1, 3, 0, 0));
        send_pixel(make_pixel(4095, 4095, 4096, 4096, 11, 4095, 4095));
        send_pixel(make_pixel(0, 399, 0, 0, 13, 7, 9));
        send_pixel(make_pixel(100, 10, 1, 50, 5, 3, 20));
        send_pixel(make_pixel(100, 10, 50, 1, 14, 20, 3));
        send_pixel(make_pixel(600, 300, 8191, 8191, 10, 4095, 0));
        send_pixel(make_pixel(4095, 0, 4096, 1, 2, 100, 0));
        send_pixel(make_pixel(320, 200, 300, 150, 12, 299, 149));
        drain();
    endtask

    task automatic test_screen_extremes();
        set_screen(1, 1);
        send_pixel(make_pixel(0, 0, 1, 1, 4, 0, 0));
        send_pixel(make_pixel(0, 0, 2, 2, 6, 1, 1));
        send_pixel(make_pixel(5, 5, 10, 10, 15, 4, 4));
        drain();
        set_screen(0, 0);
        send_pixel(make_pixel(0, 0, 3, 3, 13, 1, 2));
        send_pixel(make_pixel(1, 0, 1, 1, 11, 0, 0));
        drain();
        set_screen(4096, 4096);
        send_pixel(make_pixel(0, 4095, 4096, 4096, 11, 2048, 1024));
        send_pixel(make_pixel(2048, 0, 2048, 4096, 14, 1000, 3000));
        drain();
        // upper data bits must be ignored
        set_screen(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(make_pixel(4095, 0, 4096, 4096, 10, 4095, 4095));
        send_pixel(make_pixel(0, 4095, 100, 100, 1, 50, 50));
        drain();
    endtask

    task automatic test_random(int items);
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_screen(640, 400);
                1: set_screen($urandom_range(1, 64), $urandom_range(1, 64));
                2: set_screen($urandom_range(1, 4096), $urandom_range(1, 4096));
                3: set_screen(4096, $urandom_range(0, 8191));
                default: set_screen($urandom_range(0, 8191), $urandom_range(0, 8191));
            endcase
            repeat (items / 6) send_pixel(random_pixel());
            drain();
        end
    endtask

    task automatic test_backpressure();
        holdoff_asked++;
        repeat (200) send_pixel(random_pixel());
        drain();
    endtask

    task automatic test_steady_stream();
        steady = 1;
        repeat (200) send_pixel(random_pixel());
        drain();
        steady = 0;
    endtask

    // Receiver: random holds outside the steady stream, plus one long hold counted here on request
    always @(posedge clk)
    begin
        if (holdoff_asked != holdoff_seen)
        begin
            holdoff_seen <= holdoff_asked;
            holdoff_left <= HOLDOFF_CYCLES;
            pixel_stall  <= 1'b1;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            pixel_stall  <= 1'b1;
        end
        else
            pixel_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (colors_due.size() == 0)
            begin
                $display("%0t: pixel with no request pending r=%0d g=%0d b=%0d",
                         $time, red, green, blue);
                errors++;
            end
            else
            begin
                want = colors_due.pop_front();
                if (red !== want.r)
                begin
                    $display("%0t: red expected %0d actual %0d", $time, want.r, red);
                    errors++;
                end
                if (green !== want.g)
                begin
                    $display("%0t: green expected %0d actual %0d", $time, want.g, green);
                    errors++;
                end
                if (blue !== want.b)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time, want.b, blue);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (pixel_valid && !pixel_stall) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int missing;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_screen_extremes();
        test_random(1200);
        set_screen(640, 400);
        test_backpressure();
        test_steady_stream();
        missing = colors_due.size();
        if (missing != 0)
            $display("%0t: %0d pixels never returned", $time, missing);
        if (errors == 0 && missing == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
